// ===== rtl/core/pt82_pkg.sv =====
package pt82_pkg;

	localparam int NUM_BITS = 82;
	localparam int CNT_W = 7;
	localparam int TRIAL_PRIME_COUNT = 32;
	localparam int MR_BASE_COUNT = 13;
	localparam int BASE_IDX_W = 4;

	localparam logic [NUM_BITS-1:0] BOUND = {18'h2be69, 64'h51adc5b22410a5fd};

	localparam logic [7:0] TRIAL_PRIMES [32] = '{
		8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17, 8'd19, 8'd23,
		8'd29, 8'd31, 8'd37, 8'd41, 8'd43, 8'd47, 8'd53, 8'd59,
		8'd61, 8'd67, 8'd71, 8'd73, 8'd79, 8'd83, 8'd89, 8'd97,
		8'd101, 8'd103, 8'd107, 8'd109, 8'd113, 8'd127, 8'd131, 8'd137
	};

	localparam logic [5:0] MR_BASES [13] = '{
		6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31,
		6'd37, 6'd41
	};

	typedef enum logic [1:0] {
		VERDICT_COMPOSITE  = 2'd0,
		VERDICT_PRIME      = 2'd1,
		VERDICT_NOT_TESTED = 2'd2
	} verdict_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_TRIAL,
		ST_TRIAL_CHK,
		ST_DECOMP,
		ST_POW_INIT,
		ST_POW_SQ,
		ST_POW_SQ_W,
		ST_POW_MB,
		ST_POW_MB_W,
		ST_POW_NEXT,
		ST_CHECK,
		ST_SQ_TEST,
		ST_SQ_W,
		ST_SQ_CHK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic     load;
		logic     trial_step;
		logic     shift_t;
		logic     pow_init;
		logic     cnt_dec;
		logic     sq_init;
		logic     cnt_inc;
		logic     base_next;
		logic     mul_start;
		logic     mul_sel_base;
		logic     emit;
		verdict_t verdict;
	} cmd_t;

	typedef struct packed {
		logic even;
		logic out_of_range;
		logic trial_hit;
		logic cnt_zero;
		logic t_odd;
		logic e_bit;
		logic y_one;
		logic y_nm1;
		logic sq_more;
		logic last_base;
		logic mul_busy;
		logic mul_done;
		logic out_free;
	} sts_t;

	// (x + y) mod n for x, y < n
	function automatic logic [NUM_BITS-1:0] add_mod(
		input logic [NUM_BITS-1:0] x,
		input logic [NUM_BITS-1:0] y,
		input logic [NUM_BITS-1:0] n
	);
		logic [NUM_BITS:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, n}) begin
			s = s - {1'b0, n};
		end
		return s[NUM_BITS-1:0];
	endfunction

endpackage

// ===== rtl/core/pt82_mulmod.sv =====
module pt82_mulmod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pt82_pkg::NUM_BITS-1:0] a,
	input  logic [pt82_pkg::NUM_BITS-1:0] b,
	input  logic [pt82_pkg::NUM_BITS-1:0] n,
	output logic                          busy,
	output logic                          done,
	output logic [pt82_pkg::NUM_BITS-1:0] product
);
	import pt82_pkg::*;

	logic [NUM_BITS-1:0] acc_q, a_q, b_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                phase_q, busy_q, done_q;
	logic                advance;

	// double on phase 0, add multiplicand on phase 1 when the bit is set
	assign advance = busy_q && (phase_q || !b_q[NUM_BITS-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= CNT_W'(NUM_BITS - 1);
			end else if (busy_q) begin
				phase_q <= !phase_q && b_q[NUM_BITS-1];
				if (advance) begin
					if (cnt_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= phase_q ? add_mod(acc_q, a_q, n) : add_mod(acc_q, acc_q, n);
			if (advance) begin
				b_q <= {b_q[NUM_BITS-2:0], 1'b0};
			end
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== rtl/core/pt82_dp.sv =====
module pt82_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pt82_pkg::cmd_t         cmd,
	output pt82_pkg::sts_t         sts,
	input  logic [17:0]            value_high,
	input  logic [63:0]            value_low,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             verdict
);
	import pt82_pkg::*;

	logic [NUM_BITS-1:0]   n_q, nm1_q, t_q, y_q, mul_a, mul_p;
	logic [CNT_W-1:0]      s_q, cnt_q;
	logic [BASE_IDX_W-1:0] base_idx_q;
	logic [7:0]            res_q [TRIAL_PRIME_COUNT];
	logic                  out_valid_q;
	verdict_t              verdict_q;
	logic                  mul_busy, mul_done, hit;
	logic [NUM_BITS-1:0]   base_val;

	assign base_val = {{(NUM_BITS-6){1'b0}}, MR_BASES[base_idx_q]};
	assign mul_a    = cmd.mul_sel_base ? base_val : y_q;

	pt82_mulmod u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.a       (mul_a),
		.b       (y_q),
		.n       (n_q),
		.busy    (mul_busy),
		.done    (mul_done),
		.product (mul_p)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q   <= {value_high, value_low};
			nm1_q <= {value_high, value_low} - NUM_BITS'(1);
			t_q   <= {value_high, value_low} - NUM_BITS'(1);
			s_q   <= '0;
		end else if (cmd.shift_t) begin
			t_q <= {1'b0, t_q[NUM_BITS-1:1]};
			s_q <= s_q + 1'b1;
		end
		if (cmd.pow_init) begin
			y_q <= NUM_BITS'(1);
		end else if (mul_done) begin
			y_q <= mul_p;
		end
	end

	// one residue lane per trial prime, fed one bit of n per cycle
	always_ff @(posedge clk) begin
		for (int i = 0; i < TRIAL_PRIME_COUNT; i++) begin
			if (cmd.load) begin
				res_q[i] <= '0;
			end else if (cmd.trial_step) begin
				if ({res_q[i], n_q[cnt_q]} >= {1'b0, TRIAL_PRIMES[i]}) begin
					res_q[i] <= 8'({res_q[i], n_q[cnt_q]} - {1'b0, TRIAL_PRIMES[i]});
				end else begin
					res_q[i] <= 8'({res_q[i], n_q[cnt_q]});
				end
			end
		end
	end

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < TRIAL_PRIME_COUNT; i++) begin
			hit = hit | (res_q[i] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			base_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load || cmd.pow_init) begin
				cnt_q <= CNT_W'(NUM_BITS - 1);
			end else if (cmd.sq_init) begin
				cnt_q <= CNT_W'(1);
			end else if (cmd.trial_step || cmd.cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load) begin
				base_idx_q <= '0;
			end else if (cmd.base_next) begin
				base_idx_q <= base_idx_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			verdict_q <= cmd.verdict;
		end
	end

	always_comb begin
		sts.even         = !n_q[0];
		sts.out_of_range = (n_q[NUM_BITS-1:64] == '0) || (n_q >= BOUND);
		sts.trial_hit    = hit;
		sts.cnt_zero     = (cnt_q == '0);
		sts.t_odd        = t_q[0];
		sts.e_bit        = t_q[cnt_q];
		sts.y_one        = (y_q == NUM_BITS'(1));
		sts.y_nm1        = (y_q == nm1_q);
		sts.sq_more      = (cnt_q < s_q);
		sts.last_base    = (base_idx_q == BASE_IDX_W'(MR_BASE_COUNT - 1));
		sts.mul_busy     = mul_busy;
		sts.mul_done     = mul_done;
		sts.out_free     = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

endmodule

// ===== rtl/core/pt82_ctrl.sv =====
module pt82_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  pt82_pkg::sts_t sts,
	output pt82_pkg::cmd_t cmd
);
	import pt82_pkg::*;

	state_t   state_q, state_d;
	verdict_t res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_q   <= VERDICT_COMPOSITE;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		res_d       = res_q;
		cmd         = '0;
		cmd.verdict = res_q;
		in_stall    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CLASSIFY;
				end
			end
			ST_CLASSIFY: begin
				if (sts.even) begin
					res_d   = VERDICT_COMPOSITE;
					state_d = ST_EMIT;
				end else if (sts.out_of_range) begin
					res_d   = VERDICT_NOT_TESTED;
					state_d = ST_EMIT;
				end else begin
					state_d = ST_TRIAL;
				end
			end
			ST_TRIAL: begin
				cmd.trial_step = 1'b1;
				if (sts.cnt_zero) begin
					state_d = ST_TRIAL_CHK;
				end
			end
			ST_TRIAL_CHK: begin
				if (sts.trial_hit) begin
					res_d   = VERDICT_COMPOSITE;
					state_d = ST_EMIT;
				end else begin
					state_d = ST_DECOMP;
				end
			end
			ST_DECOMP: begin
				if (sts.t_odd) begin
					state_d = ST_POW_INIT;
				end else begin
					cmd.shift_t = 1'b1;
				end
			end
			ST_POW_INIT: begin
				cmd.pow_init = 1'b1;
				state_d      = ST_POW_SQ;
			end
			ST_POW_SQ: begin
				cmd.mul_start = 1'b1;
				state_d       = ST_POW_SQ_W;
			end
			ST_POW_SQ_W: begin
				if (sts.mul_done) begin
					state_d = sts.e_bit ? ST_POW_MB : ST_POW_NEXT;
				end
			end
			ST_POW_MB: begin
				cmd.mul_start    = 1'b1;
				cmd.mul_sel_base = 1'b1;
				state_d          = ST_POW_MB_W;
			end
			ST_POW_MB_W: begin
				if (sts.mul_done) begin
					state_d = ST_POW_NEXT;
				end
			end
			ST_POW_NEXT: begin
				if (sts.cnt_zero) begin
					state_d = ST_CHECK;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = ST_POW_SQ;
				end
			end
			ST_CHECK: begin
				if (sts.y_one || sts.y_nm1) begin
					if (sts.last_base) begin
						res_d   = VERDICT_PRIME;
						state_d = ST_EMIT;
					end else begin
						cmd.base_next = 1'b1;
						state_d       = ST_POW_INIT;
					end
				end else begin
					cmd.sq_init = 1'b1;
					state_d     = ST_SQ_TEST;
				end
			end
			ST_SQ_TEST: begin
				if (sts.sq_more) begin
					cmd.mul_start = 1'b1;
					state_d       = ST_SQ_W;
				end else begin
					res_d   = VERDICT_COMPOSITE;
					state_d = ST_EMIT;
				end
			end
			ST_SQ_W: begin
				if (sts.mul_done) begin
					state_d = ST_SQ_CHK;
				end
			end
			ST_SQ_CHK: begin
				if (sts.y_nm1) begin
					if (sts.last_base) begin
						res_d   = VERDICT_PRIME;
						state_d = ST_EMIT;
					end else begin
						cmd.base_next = 1'b1;
						state_d       = ST_POW_INIT;
					end
				end else begin
					cmd.cnt_inc = 1'b1;
					state_d     = ST_SQ_TEST;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free) else $error("result written over a pending transfer");
	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !sts.mul_busy) else $error("multiply started while busy");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid) |=> state_q == ST_CLASSIFY)
		else $error("accepted item not classified");

endmodule

// ===== rtl/core/prime_test_82bit.sv =====
// Sequence: even or untested n is classified and emitted without trial division; a full
// test runs trial division and decomposition, then 13 exponentiations of 82 squarings
// plus one multiply per set exponent bit; each modular multiply is bit-serial shift and add.
// Throughput: one item at a time, set by the single shared modular multiplier.
// Reset: arst_n asynchronous, active low; clears the controller and the output valid.
module prime_test_82bit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [17:0] value_high,
	input  logic [63:0] value_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  verdict
);
	import pt82_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// controller sequences: classify, trial residues (all 32 primes in parallel lanes),
	// strip powers of two from n-1, then per base the square and multiply ladder and
	// the squaring chain looking for n-1
	pt82_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath holds n, n-1, t, s, y, the counters, the multiplier and the output register;
	// a new transfer is taken while the previous verdict waits on out_stall
	pt82_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.value_high (value_high),
		.value_low  (value_low),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.verdict    (verdict)
	);

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import pt82_pkg::*;

	// Run budget: primes are the costliest items, so the random mix keeps
	// full strong-probable-prime candidates rare and the limit is generous.
	localparam int CYCLE_LIMIT = 12_000_000;
	localparam int RANDOM_ITEMS = 140;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic [17:0] hi;
		logic [63:0] lo;
		logic        known;   // expected verdict typed in below
		verdict_t    v;
	} row_t;

	localparam int N_DIRECTED = 12;
	// Rows marked known carry their verdict; the rest go through the predictor.
	localparam row_t DIRECTED [N_DIRECTED] = '{
		'{18'h0, 64'h0, 1'b1, VERDICT_COMPOSITE},                        // zero, even
		'{18'h3ffff, 64'hffff_ffff_ffff_fffe, 1'b1, VERDICT_COMPOSITE},  // largest even
		'{18'h0, 64'hffff_ffff_ffff_ffff, 1'b1, VERDICT_NOT_TESTED},     // odd, high part zero
		'{18'h0, 64'h1, 1'b1, VERDICT_NOT_TESTED},                       // one
		'{18'h2be69, 64'h51ad_c5b2_2410_a5fd, 1'b1, VERDICT_NOT_TESTED}, // exactly the bound
		'{18'h3ffff, 64'hffff_ffff_ffff_ffff, 1'b1, VERDICT_NOT_TESTED}, // all ones
		'{18'h2be69, 64'h51ad_c5b2_2410_a5fc, 1'b1, VERDICT_COMPOSITE},  // bound - 1, even
		'{18'h3, 64'h3, 1'b1, VERDICT_COMPOSITE},                        // 3 * (2^64 + 1)
		'{18'h89, 64'h89, 1'b1, VERDICT_COMPOSITE},                      // 137 * (2^64 + 1)
		'{18'h1, 64'h5, 1'b0, VERDICT_COMPOSITE},                        // 2^64 + 5
		'{18'h1, 64'h1, 1'b0, VERDICT_COMPOSITE},                        // 2^64 + 1, no small factor
		'{18'h1, 64'hd, 1'b0, VERDICT_COMPOSITE}                         // 2^64 + 13, prime
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [17:0] value_high;
	logic [63:0] value_low;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  verdict;

	prime_test_82bit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value_high(value_high),
		.value_low(value_low),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.verdict(verdict)
	);

	// Pending verdicts, oldest first; typed verdicts queued by the driver
	// alongside each item so the monitor can pick them up at the transfer.
	verdict_t  verdicts_due[$];
	row_t      rows_offered[$];
	int        n_errors = 0;
	int        n_sent = 0;
	int        n_seen = 0;
	int        n_by_verdict [3] = '{0, 0, 0};
	longint    cycles = 0;
	bit        quiet = 0;   // stretch with no idling on either side
	bit        stim_done = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------
	// Predictor: exact 82-bit modular arithmetic on wide vectors.
	// ---------------------------------------------------------------
	function automatic logic [81:0] mulmod82(logic [81:0] a, logic [81:0] b, logic [81:0] n);
		logic [163:0] prod;
		prod = {82'b0, a} * {82'b0, b};
		return 82'(prod % {82'b0, n});
	endfunction

	function automatic logic [81:0] powmod82(logic [81:0] b, logic [81:0] e, logic [81:0] n);
		logic [81:0] r;
		r = 82'd1;
		for (int k = 81; k >= 0; k--) begin
			r = mulmod82(r, r, n);
			if (e[k]) begin
				r = mulmod82(r, b, n);
			end
		end
		return r;
	endfunction

	function automatic verdict_t primality_of(logic [81:0] n);
		logic [81:0] nm1;
		logic [81:0] odd_part;
		logic [81:0] y;
		int          twos;
		bit          witness_ok;
		if (!n[0]) begin
			return VERDICT_COMPOSITE;
		end
		if (n[81:64] == 18'd0 || n >= BOUND) begin
			return VERDICT_NOT_TESTED;
		end
		for (int i = 0; i < TRIAL_PRIME_COUNT && i < 32; i++) begin
			if (n % {74'b0, TRIAL_PRIMES[i]} == 82'd0) begin
				return VERDICT_COMPOSITE;
			end
		end
		nm1 = n - 82'd1;
		odd_part = nm1;
		twos = 0;
		while (!odd_part[0]) begin
			odd_part = odd_part >> 1;
			twos++;
		end
		for (int b = 0; b < MR_BASE_COUNT; b++) begin
			y = powmod82({76'b0, MR_BASES[b]}, odd_part, n);
			witness_ok = (y == 82'd1) || (y == nm1);
			for (int i = 1; i < twos && !witness_ok; i++) begin
				y = mulmod82(y, y, n);
				witness_ok = (y == nm1);
			end
			if (!witness_ok) begin
				return VERDICT_COMPOSITE;
			end
		end
		return VERDICT_PRIME;
	endfunction

	// ---------------------------------------------------------------
	// Input side.
	// ---------------------------------------------------------------
	function automatic int pick_gap();
		if (quiet) begin
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			return $urandom_range(10, 60);   // occasional long gap
		end
		return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
	endfunction

	// Offer one item and hold it until the transfer; then optionally drop valid.
	task automatic offer_value(row_t r);
		int gap;
		rows_offered.push_back(r);
		in_valid <= 1'b1;
		value_high <= r.hi;
		value_low <= r.lo;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		n_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Random odd n inside the tested window.
	function automatic logic [81:0] odd_in_window();
		logic [81:0] n;
		n = {18'($urandom_range(1, 18'h2be68)), $urandom, $urandom};
		n[0] = 1'b1;
		return n;
	endfunction

	function automatic row_t random_row();
		row_t        r;
		logic [81:0] n;
		logic [81:0] q;
		int          kind;
		int          p;
		kind = $urandom_range(0, 99);
		r.known = 1'b0;
		r.v = VERDICT_COMPOSITE;
		if (kind < 35) begin
			// even, anywhere
			n = {18'($urandom), $urandom, $urandom};
			n[0] = 1'b0;
		end else if (kind < 47) begin
			// odd with zero high part
			n = {18'b0, $urandom, $urandom};
			n[0] = 1'b1;
		end else if (kind < 60) begin
			// odd at or above the bound
			n = {18'($urandom_range(18'h2be69, 18'h3ffff)), $urandom, $urandom};
			n[0] = 1'b1;
			if (n < BOUND) begin
				n = BOUND + {$urandom_range(0, 1000), 1'b0};
			end
		end else if (kind < 96) begin
			// odd multiple of one trial prime, inside the window
			p = TRIAL_PRIMES[$urandom_range(0, TRIAL_PRIME_COUNT - 1)];
			do begin
				q = odd_in_window() / p;
				q[0] = 1'b1;
				n = q * p;
			end while (n[81:64] == 18'd0 || n >= BOUND);
		end else begin
			// full strong-probable-prime candidate
			n = odd_in_window();
		end
		r.hi = n[81:64];
		r.lo = n[63:0];
		return r;
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		value_high = '0;
		value_low = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			offer_value(DIRECTED[i]);
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= 60 && i < 90);
			offer_value(random_row());
		end
		in_valid <= 1'b0;
		stim_done = 1;
	end

	// ---------------------------------------------------------------
	// Output side: random stall, mostly short bursts.
	// ---------------------------------------------------------------
	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (quiet) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50)
				: $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Monitor: input transfers load expectations, output transfers check.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		row_t     r;
		verdict_t want;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (in_valid && !in_stall) begin
				if (rows_offered.size() == 0) begin
					$error("input transfer with nothing offered");
					n_errors++;
				end else begin
					r = rows_offered.pop_front();
					want = r.known ? r.v : primality_of({r.hi, r.lo});
					verdicts_due.push_back(want);
				end
			end
			if (out_valid && !out_stall) begin
				n_seen++;
				if (verdicts_due.size() == 0) begin
					$error("verdict %0d arrived with none expected", verdict);
					n_errors++;
				end else begin
					want = verdicts_due.pop_front();
					if (verdict != want) begin
						$error("verdict: expected %0d, actual %0d", want, verdict);
						n_errors++;
					end
					if (want <= VERDICT_NOT_TESTED) begin
						n_by_verdict[want]++;
					end
				end
			end
		end
	end

	// End of run, and the cycle watchdog.
	initial begin
		wait (stim_done);
		while (verdicts_due.size() != 0 || rows_offered.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d numbers sent, %0d verdicts checked in %0d cycles", n_sent, n_seen,
			cycles);
		$display("composite %0d, prime %0d, not tested %0d", n_by_verdict[0],
			n_by_verdict[1], n_by_verdict[2]);
		if (n_errors == 0 && verdicts_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
rtl/core/pt82_pkg.sv
rtl/core/pt82_mulmod.sv
rtl/core/pt82_dp.sv
rtl/core/pt82_ctrl.sv
rtl/core/prime_test_82bit.sv
verif/tb.sv
